// File: rtl/bce_pkg.sv
// shared types and constants for the bezier curve evaluator
// no dependencies

package bce_pkg;

  localparam int CoordW      = 24;
  localparam int ParamW      = 17;
  localparam int CmdW        = 2;
  localparam int StatusW     = 2;
  localparam int Lanes       = 4;
  localparam int InTdataW    = 120;
  localparam int OutTdataW   = 104;
  localparam int MaxPointsDef = 16;
  localparam int DimDef      = 3;
  localparam int FracW       = 16;
  localparam int DrainCycles = 3;

  localparam logic [ParamW-1:0] ParamOne = ParamW'(1 << FracW);

  // request commands
  localparam logic [CmdW-1:0] CMD_START  = 2'd0;
  localparam logic [CmdW-1:0] CMD_APPEND = 2'd1;
  localparam logic [CmdW-1:0] CMD_EVAL   = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatusW-1:0] STAT_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STAT_DROP  = 2'd2;

  typedef enum logic [1:0] {
    RD_FIRST,
    RD_STEP,
    RD_RESULT
  } rd_kind_e;

  // controller to datapath command group
  typedef struct packed {
    logic                 pt_wr_en;
    logic                 rd_en;
    logic                 rd_work;
    rd_kind_e             kind;
    logic [StatusW-1:0]   status;
  } dp_cmd_t;

endpackage

// File: rtl/bce_datapath.sv
// point and scratch memories, lerp pipeline and result register
// depends on bce_pkg

module bce_datapath import bce_pkg::*; #(
  parameter int MaxPoints = MaxPointsDef,
  parameter int Dim       = DimDef,
  parameter int AddrW     = (MaxPoints > 1) ? $clog2(MaxPoints) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [CmdW-1:0]          command_i,
  input  logic [Dim*CoordW-1:0]    coords_i,
  input  logic [ParamW-1:0]        curve_param_i,
  input  dp_cmd_t                  cmd_i,
  input  logic [AddrW-1:0]         pt_wr_addr_i,
  input  logic [AddrW-1:0]         rd_addr_i,
  input  logic                     out_ready_i,
  output logic                     out_free_o,
  output logic                     out_valid_o,
  output logic [Lanes*CoordW-1:0]  out_points_o,
  output logic [StatusW-1:0]       out_status_o
);

  localparam int RowW  = Dim * CoordW;
  localparam int DiffW = CoordW + 1;
  localparam int ProdW = DiffW + ParamW + 1;
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(1 << (FracW - 1));

  logic [RowW-1:0] point_mem [MaxPoints];
  logic [RowW-1:0] work_mem  [MaxPoints];
  logic [RowW-1:0] pt_rdata_q, wk_rdata_q, rdata;
  logic [Lanes*CoordW-1:0] rdata_wide;
  logic [RowW-1:0] wr_row;

  logic [ParamW-1:0] u_q;

  logic               s1_v_q, s2_v_q, s3_v_q;
  rd_kind_e           s1_kind_q;
  logic               s1_work_q;
  logic [StatusW-1:0] s1_status_q;
  logic [AddrW-1:0]   s1_addr_q, s2_addr_q, s3_addr_q;

  logic signed [CoordW-1:0] prev_q [Dim];
  logic signed [DiffW-1:0]  diff_q [Dim];
  logic signed [CoordW-1:0] a2_q   [Dim];
  logic signed [ProdW-1:0]  prod_q [Dim];
  logic signed [CoordW-1:0] a3_q   [Dim];

  logic                     out_v_q;
  logic [CoordW-1:0]        out_pt_q [Lanes];
  logic [StatusW-1:0]       out_st_q;

  // parameter latched on an evaluate request, clamped to one
  always_ff @(posedge clk_i) begin
    if (accept_i && command_i == CMD_EVAL) begin
      u_q <= (curve_param_i > ParamOne) ? ParamOne : curve_param_i;
    end
  end

  // control point memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_wr_en) begin
      point_mem[pt_wr_addr_i] <= coords_i;
    end
    if (cmd_i.rd_en) begin
      pt_rdata_q <= point_mem[rd_addr_i];
    end
  end

  // scratch memory, written back by the last pipeline stage
  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      work_mem[s3_addr_q] <= wr_row;
    end
    if (cmd_i.rd_en) begin
      wk_rdata_q <= work_mem[rd_addr_i];
    end
  end

  assign rdata      = s1_work_q ? wk_rdata_q : pt_rdata_q;
  assign rdata_wide = (Lanes*CoordW)'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.rd_en;
      s2_v_q <= s1_v_q && (s1_kind_q == RD_STEP);
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q   <= cmd_i.kind;
    s1_work_q   <= cmd_i.rd_work;
    s1_status_q <= cmd_i.status;
    s1_addr_q   <= rd_addr_i;
    s2_addr_q   <= s1_addr_q - AddrW'(1);
    s3_addr_q   <= s2_addr_q;
    for (int j = 0; j < Dim; j++) begin
      if (s1_v_q) begin
        prev_q[j] <= rdata[j*CoordW +: CoordW];
      end
      diff_q[j] <= DiffW'($signed(rdata[j*CoordW +: CoordW])) - DiffW'(prev_q[j]);
      a2_q[j]   <= prev_q[j];
      prod_q[j] <= diff_q[j] * $signed({1'b0, u_q});
      a3_q[j]   <= a2_q[j];
    end
  end

  // a + floor((d * u + half) / 2^16), stays between its operands
  always_comb begin
    logic signed [ProdW-1:0] rnd;
    wr_row = '0;
    for (int j = 0; j < Dim; j++) begin
      rnd = (prod_q[j] + RoundHalf) >>> FracW;
      wr_row[j*CoordW +: CoordW] = a3_q[j] + rnd[CoordW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_v_q && s1_kind_q == RD_RESULT) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s1_kind_q == RD_RESULT) begin
      out_st_q <= s1_status_q;
      for (int j = 0; j < Lanes; j++) begin
        if (j < Dim && s1_status_q != STAT_EMPTY) begin
          out_pt_q[j] <= rdata_wide[j*CoordW +: CoordW];
        end else begin
          out_pt_q[j] <= '0;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < Lanes; j++) begin
      out_points_o[j*CoordW +: CoordW] = out_pt_q[j];
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_status_o = out_st_q;
  assign out_free_o   = !out_v_q || out_ready_i;

endmodule

// File: rtl/bce_controller.sv
// sequencer for loading points and the de casteljau rounds
// depends on bce_pkg

module bce_controller import bce_pkg::*; #(
  parameter int MaxPoints = MaxPointsDef,
  parameter int AddrW     = (MaxPoints > 1) ? $clog2(MaxPoints) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CmdW-1:0]  command_i,
  input  logic             out_free_i,
  output logic             in_ready_o,
  output dp_cmd_t          cmd_o,
  output logic [AddrW-1:0] pt_wr_addr_o,
  output logic [AddrW-1:0] rd_addr_o
);

  localparam int CntW = $clog2(MaxPoints + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] len_q, len_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            src_work_q, src_work_d;
  logic [1:0]      drain_q, drain_d;
  logic            accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    len_d      = len_q;
    idx_d      = idx_q;
    src_work_d = src_work_q;
    drain_d    = drain_q;
    cmd_o      = '0;
    cmd_o.kind = RD_STEP;
    pt_wr_addr_o = '0;
    rd_addr_o    = idx_q[AddrW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_START: begin
              cmd_o.pt_wr_en = 1'b1;
              count_d = CntW'(1);
              ovf_d   = 1'b0;
            end
            CMD_APPEND: begin
              if (count_q < CntW'(MaxPoints)) begin
                cmd_o.pt_wr_en = 1'b1;
                pt_wr_addr_o   = count_q[AddrW-1:0];
                count_d        = count_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_EVAL: begin
              idx_d      = '0;
              src_work_d = 1'b0;
              len_d      = count_q - CntW'(1);
              state_d    = (count_q > CntW'(1)) ? ST_ROUND : ST_FINAL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROUND: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_work = src_work_q;
        cmd_o.kind    = (idx_q == '0) ? RD_FIRST : RD_STEP;
        if (idx_q == len_q) begin
          drain_d = 2'(DrainCycles - 1);
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_q == '0) begin
          idx_d      = '0;
          src_work_d = 1'b1;
          if (len_q == CntW'(1)) begin
            state_d = ST_FINAL;
          end else begin
            len_d   = len_q - CntW'(1);
            state_d = ST_ROUND;
          end
        end else begin
          drain_d = drain_q - 2'd1;
        end
      end
      ST_FINAL: begin
        rd_addr_o = '0;
        if (out_free_i) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_work = src_work_q;
          cmd_o.kind    = RD_RESULT;
          cmd_o.status  = (count_q == '0) ? STAT_EMPTY : (ovf_q ? STAT_DROP : STAT_OK);
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      len_q      <= '0;
      idx_q      <= '0;
      src_work_q <= 1'b0;
      drain_q    <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      len_q      <= len_d;
      idx_q      <= idx_d;
      src_work_q <= src_work_d;
      drain_q    <= drain_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPoints))
    else $error("point count above store depth");

  a_result_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && cmd_o.kind == RD_RESULT) |-> out_free_i)
    else $error("result read issued while output register busy");

  a_round_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (idx_q <= len_q && len_q < count_q))
    else $error("round index beyond live points");

  a_eval_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_EVAL && count_q > CntW'(1)) |=> (state_q == ST_ROUND))
    else $error("evaluate request did not start a round");
`endif

endmodule

// File: rtl/bezier_curve_evaluator.sv
// top level of the bezier curve evaluator, stream in and stream out
// depends on bce_pkg, bce_controller and bce_datapath

// Loads up to MAX_POINTS control points of DIM signed Q8.15 coordinates and
// evaluates the Bezier curve they define by de Casteljau interpolation with
// round-half-up. Command 0 starts a curve with the given point, command 1
// appends a point (dropped and flagged once the store is full), command 2
// evaluates at curve_param (Q1.16, 65536 is 1.0, larger values clamp) and
// returns one result; command 3 is ignored. Start and append requests are
// taken one per cycle while no evaluation runs. An evaluation over n points
// runs n-1 rounds through one shared lerp pipeline with all coordinate
// lanes side by side; a round of k steps costs k+1 memory reads, one per
// cycle, plus a drain so the write-back lands before the next round reads
// it. The evaluation time is set by the single read port of the scratch
// memory and the pipeline depth.
// A finished result sits in the output register so a new request can be
// taken while the consumer stalls; a further evaluation waits only for that
// register to empty.

module bezier_curve_evaluator import bce_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int DIM        = DimDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command [1:0], coord_0 [25:2], coord_1 [49:26], coord_2 [73:50],
  // coord_3 [97:74], curve_param [114:98], zero fill above
  input  logic [InTdataW-1:0]  s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_0 [23:0], point_1 [47:24], point_2 [71:48], point_3 [95:72],
  // status [97:96], zero fill above
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready
);

  localparam int AddrW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CmdLo  = 0;
  localparam int CrdLo  = CmdLo + CmdW;
  localparam int ParLo  = CrdLo + Lanes * CoordW;
  localparam int OutStLo = Lanes * CoordW;

  dp_cmd_t             dp_cmd;
  logic [AddrW-1:0]    pt_wr_addr;
  logic [AddrW-1:0]    rd_addr;
  logic                out_free;
  logic                accept;
  logic [CmdW-1:0]     command;
  logic [ParamW-1:0]   curve_param;
  logic [Lanes*CoordW-1:0] points;
  logic [StatusW-1:0]  status;

  // unpack the request fields
  assign command     = s_axis_tdata[CmdLo +: CmdW];
  assign curve_param = s_axis_tdata[ParLo +: ParamW];
  assign accept      = s_axis_tvalid && s_axis_tready;

  // sequencer: point count, overflow flag, round and step counters
  bce_controller #(
    .MaxPoints (MAX_POINTS),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .command_i    (command),
    .out_free_i   (out_free),
    .in_ready_o   (s_axis_tready),
    .cmd_o        (dp_cmd),
    .pt_wr_addr_o (pt_wr_addr),
    .rd_addr_o    (rd_addr)
  );

  // memories, interpolation pipeline and output register; only the
  // coordinates below DIM are stored
  bce_datapath #(
    .MaxPoints (MAX_POINTS),
    .Dim       (DIM),
    .AddrW     (AddrW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (command),
    .coords_i      (s_axis_tdata[CrdLo +: DIM*CoordW]),
    .curve_param_i (curve_param),
    .cmd_i         (dp_cmd),
    .pt_wr_addr_i  (pt_wr_addr),
    .rd_addr_i     (rd_addr),
    .out_ready_i   (m_axis_tready),
    .out_free_o    (out_free),
    .out_valid_o   (m_axis_tvalid),
    .out_points_o  (points),
    .out_status_o  (status)
  );

  // pack the result, unused lanes already read as zero
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0 +: Lanes*CoordW]  = points;
    m_axis_tdata[OutStLo +: StatusW] = status;
  end

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the bezier curve evaluator stream block
// depends on bce_pkg and bezier_curve_evaluator; results are checked against an in-bench
// de casteljau predictor or typed directed expectations
`timescale 1ns / 1ps

module tb_top;
  import bce_pkg::*;

  localparam int MaxPts       = MaxPointsDef;
  localparam int DimN         = DimDef;
  localparam int ItemTarget   = 1700;
  localparam int CycleLimit   = 5_000_000;
  // covers the longest evaluation plus a long consumer stall
  localparam int SettleCycles = 300;
  localparam int DirRows      = 16;

  localparam logic [CmdW-1:0]   CmdUnused = 2'd3;
  localparam logic [CoordW-1:0] CoordMax  = 24'h7FFFFF;
  localparam logic [CoordW-1:0] CoordMin  = 24'h800000;
  localparam logic [CoordW-1:0] CoordZero = 24'h000000;
  localparam logic [CoordW-1:0] CoordOne  = 24'h000001;

  // request fields from the lowest bit up: command, coord_0..3, curve_param
  typedef struct packed {
    logic [ParamW-1:0]            u;
    logic [Lanes-1:0][CoordW-1:0] crd;
    logic [CmdW-1:0]              cmd;
  } curve_req_t;

  // result fields from the lowest bit up: point_0..3, status
  typedef struct packed {
    logic [StatusW-1:0]           status;
    logic [Lanes-1:0][CoordW-1:0] pt;
  } curve_res_t;

  localparam int ResW = $bits(curve_res_t);

  // one line of the directed table; want is used only when typed is set
  typedef struct packed {
    logic [CmdW-1:0]              cmd;
    logic [Lanes-1:0][CoordW-1:0] crd;
    logic [ParamW-1:0]            u;
    logic [4:0]                   rep;
    logic                         typed;
    curve_res_t                   want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  bezier_curve_evaluator #(
    .MAX_POINTS(MaxPts),
    .DIM       (DimN)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state: loaded control points, how many, and the drop flag
  logic signed [CoordW-1:0] ctrl_pts [MaxPts][DimN];
  int unsigned              pts_loaded = 0;
  bit                       pts_dropped = 1'b0;

  curve_res_t expected_points_q [$];

  int unsigned cycle_cnt = 0;
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned evals_sent = 0;
  int unsigned drop_evals = 0;
  int unsigned noise_sent = 0;
  int unsigned results_seen = 0;
  bit          no_idle = 1'b0;

  // updates the predictor for one accepted request; returns 1 when a result is due
  function automatic bit predict_curve(input curve_req_t rq, output curve_res_t res);
    longint w [MaxPts][DimN];
    longint u;
    longint d;
    res = '0;
    case (rq.cmd)
      CMD_START: begin
        for (int j = 0; j < DimN; j++) ctrl_pts[0][j] = rq.crd[j];
        pts_loaded  = 1;
        pts_dropped = 1'b0;
        return 1'b0;
      end
      CMD_APPEND: begin
        // append on an empty store simply lands in slot zero
        if (pts_loaded < MaxPts) begin
          for (int j = 0; j < DimN; j++) ctrl_pts[pts_loaded][j] = rq.crd[j];
          pts_loaded++;
        end else begin
          pts_dropped = 1'b1;
        end
        return 1'b0;
      end
      CMD_EVAL: begin
        if (pts_loaded == 0) begin
          res.status = STAT_EMPTY;
          return 1'b1;
        end
        u = (rq.u > ParamOne) ? longint'(ParamOne) : longint'(rq.u);
        for (int i = 0; i < pts_loaded; i++)
          for (int j = 0; j < DimN; j++) w[i][j] = longint'(ctrl_pts[i][j]);
        // each round folds neighbor pairs with round-half-up lerp
        for (int r = 1; r < pts_loaded; r++)
          for (int i = 0; i + r < pts_loaded; i++)
            for (int j = 0; j < DimN; j++) begin
              d = w[i+1][j] - w[i][j];
              w[i][j] = w[i][j] + ((d * u + 32768) >>> FracW);
            end
        for (int j = 0; j < DimN; j++) res.pt[j] = CoordW'(w[0][j]);
        res.status = pts_dropped ? STAT_DROP : STAT_OK;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0d] %s: got %0h, expected %0h", cycle_cnt, what, got, want);
    err_count++;
  endtask

  // every accepted result is matched against the oldest pending expectation
  task automatic check_result(input curve_res_t got);
    curve_res_t want;
    results_seen++;
    if (expected_points_q.size() == 0) begin
      report_mismatch("result with nothing pending", longint'(got.status), '0);
    end else begin
      want = expected_points_q.pop_front();
      for (int k = 0; k < Lanes; k++)
        if (got.pt[k] !== want.pt[k])
          report_mismatch($sformatf("point_%0d", k), longint'(got.pt[k]),
                          longint'(want.pt[k]));
      if (got.status !== want.status)
        report_mismatch("status", longint'(got.status), longint'(want.status));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      check_result(curve_res_t'(m_axis_tdata[ResW-1:0]));
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_cnt, expected_points_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // idle lengths: mostly short, sometimes medium, rarely long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // consumer: alternates ready and stalled stretches, no stalls while no_idle is set
  initial begin
    int hold;
    bit stall;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        stall = !no_idle && ($urandom_range(0, 2) == 0);
        hold  = stall ? idle_len() : $urandom_range(1, 12);
        m_axis_tready <= !stall;
      end
    end
  end

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 19))
      0:       return CoordMax;
      1:       return CoordMin;
      2:       return CoordZero;
      default: return CoordW'($urandom());
    endcase
  endfunction

  function automatic logic [ParamW-1:0] rand_param();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ParamOne;
      2:       return ParamW'($urandom_range(65537, 131071));  // clamps to one
      default: return ParamW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic curve_req_t rand_req(input logic [CmdW-1:0] cmd);
    curve_req_t rq;
    rq.cmd = cmd;
    for (int k = 0; k < Lanes; k++) rq.crd[k] = rand_coord();
    rq.u = rand_param();
    return rq;
  endfunction

  // drives one request at the falling edge, waits for the handshake, then predicts
  task automatic send_request(input curve_req_t rq, input bit use_typed,
                              input curve_res_t typed_res);
    int gap;
    curve_res_t res;
    gap = (no_idle || $urandom_range(0, 1)) ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'(rq);
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    if (rq.cmd == CmdUnused) noise_sent++;
    else items_sent++;
    if (predict_curve(rq, res)) begin
      evals_sent++;
      if (res.status == STAT_DROP) drop_evals++;
      if (use_typed) res = typed_res;
      expected_points_q = {expected_points_q, res};
    end
  endtask

  task automatic send_cmd(input logic [CmdW-1:0] cmd);
    send_request(rand_req(cmd), 1'b0, '0);
  endtask

  // hold off the sender until every pending result has been seen
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_points_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles + 4) @(posedge clk_i);
  endtask

  function automatic dir_row_t mk_row(
    input logic [CmdW-1:0] cmd, input logic [CoordW-1:0] c0, c1, c2, c3,
    input logic [ParamW-1:0] u, input int rep, input bit typed,
    input logic [StatusW-1:0] st, input logic [CoordW-1:0] w0, w1, w2);
    dir_row_t row;
    row.cmd         = cmd;
    row.crd         = {c3, c2, c1, c0};
    row.u           = u;
    row.rep         = 5'(rep);
    row.typed       = typed;
    row.want        = '0;
    row.want.status = st;
    row.want.pt[0]  = w0;
    row.want.pt[1]  = w1;
    row.want.pt[2]  = w2;
    return row;
  endfunction

  initial begin
    dir_row_t   dir_tab [DirRows];
    curve_req_t rq;
    int         npts;
    int         pick;
    bit         paused_mid;

    // directed table: typed expectations where the answer is plain, predictor otherwise
    //                     cmd         c0        c1        c2         c3        u          rep
    dir_tab[0]  = mk_row(CMD_EVAL,   CoordZero, CoordZero, CoordZero, CoordZero, 17'd0,    1,
                         1'b1, STAT_EMPTY, CoordZero, CoordZero, CoordZero);
    // append on an empty store behaves as the first point
    dir_tab[1]  = mk_row(CMD_APPEND, CoordMax, CoordZero, CoordMin, CoordMin, 17'd0,     1,
                         1'b0, STAT_OK, CoordZero, CoordZero, CoordZero);
    dir_tab[2]  = mk_row(CMD_EVAL,   CoordZero, CoordZero, CoordZero, CoordZero, ParamOne, 1,
                         1'b1, STAT_OK, CoordMax, CoordZero, CoordMin);
    dir_tab[3]  = mk_row(CMD_START,  CoordMin, CoordMax, CoordZero, CoordMax, 17'd0,     1,
                         1'b0, STAT_OK, CoordZero, CoordZero, CoordZero);
    dir_tab[4]  = mk_row(CMD_APPEND, CoordMax, CoordMin, CoordOne, CoordZero, 17'd0,     1,
                         1'b0, STAT_OK, CoordZero, CoordZero, CoordZero);
    // u of zero lands on the first point, u of one on the last
    dir_tab[5]  = mk_row(CMD_EVAL,   CoordZero, CoordZero, CoordZero, CoordZero, 17'd0,    1,
                         1'b1, STAT_OK, CoordMin, CoordMax, CoordZero);
    dir_tab[6]  = mk_row(CMD_EVAL,   CoordZero, CoordZero, CoordZero, CoordZero, ParamOne, 1,
                         1'b1, STAT_OK, CoordMax, CoordMin, CoordOne);
    // parameter above one clamps
    dir_tab[7]  = mk_row(CMD_EVAL,   CoordMax, CoordMax, CoordMax, CoordMax, 17'h1FFFF,  1,
                         1'b1, STAT_OK, CoordMax, CoordMin, CoordOne);
    dir_tab[8]  = mk_row(CMD_EVAL,   CoordZero, CoordZero, CoordZero, CoordZero, 17'd32768, 1,
                         1'b0, STAT_OK, CoordZero, CoordZero, CoordZero);
    // unused command must leave the curve alone
    dir_tab[9]  = mk_row(CmdUnused,  CoordMax, CoordMax, CoordMax, CoordMax, 17'h1FFFF,  1,
                         1'b0, STAT_OK, CoordZero, CoordZero, CoordZero);
    dir_tab[10] = mk_row(CMD_EVAL,   CoordZero, CoordZero, CoordZero, CoordZero, 17'd0,    1,
                         1'b1, STAT_OK, CoordMin, CoordMax, CoordZero);
    // fill the store and drop one point past capacity
    dir_tab[11] = mk_row(CMD_APPEND, CoordZero, CoordZero, CoordZero, CoordZero, 17'd0,    15,
                         1'b0, STAT_OK, CoordZero, CoordZero, CoordZero);
    dir_tab[12] = mk_row(CMD_EVAL,   CoordZero, CoordZero, CoordZero, CoordZero, 17'd0,    1,
                         1'b1, STAT_DROP, CoordMin, CoordMax, CoordZero);
    dir_tab[13] = mk_row(CMD_EVAL,   CoordZero, CoordZero, CoordZero, CoordZero, 17'd40000, 1,
                         1'b0, STAT_OK, CoordZero, CoordZero, CoordZero);
    // a new start clears the drop flag; a single point is its own curve
    dir_tab[14] = mk_row(CMD_START,  24'h123456, 24'hFEDCBA, CoordZero, 24'hFFFFFF, 17'd0, 1,
                         1'b0, STAT_OK, CoordZero, CoordZero, CoordZero);
    dir_tab[15] = mk_row(CMD_EVAL,   CoordZero, CoordZero, CoordZero, CoordZero, 17'd21845, 1,
                         1'b1, STAT_OK, 24'h123456, 24'hFEDCBA, CoordZero);

    paused_mid = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < DirRows; k++) begin
      for (int r = 0; r < dir_tab[k].rep; r++) begin
        // repeated rows get fresh random coordinates
        rq = (dir_tab[k].rep > 1) ? rand_req(dir_tab[k].cmd)
                                  : curve_req_t'{u: dir_tab[k].u, crd: dir_tab[k].crd,
                                                 cmd: dir_tab[k].cmd};
        send_request(rq, dir_tab[k].typed, dir_tab[k].want);
      end
    end
    wait_idle();

    // random part: mostly whole curves (start, appends, evaluations), some noise
    while (items_sent < ItemTarget) begin
      no_idle = ($urandom_range(0, 7) == 0);
      if (!paused_mid && items_sent >= ItemTarget / 2) begin
        wait_idle();
        paused_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_cmd(CmdUnused);
      end else if (pick < 14) begin
        // extend the current curve, possibly past capacity
        repeat ($urandom_range(1, 3)) send_cmd(CMD_APPEND);
        send_cmd(CMD_EVAL);
      end else begin
        npts = ($urandom_range(0, 6) == 0) ? $urandom_range(12, MaxPts + 4)
                                           : $urandom_range(1, 6);
        send_cmd(CMD_START);
        repeat (npts - 1) send_cmd(CMD_APPEND);
        repeat ($urandom_range(1, 4)) send_cmd(CMD_EVAL);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_points_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d requests (%0d evaluations, %0d with dropped points) and %0d ignored",
             items_sent, evals_sent, drop_evals, noise_sent);
    $display("checked %0d results in %0d cycles, %0d errors", results_seen, cycle_cnt, err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bce_pkg.sv
rtl/bce_datapath.sv
rtl/bce_controller.sv
rtl/bezier_curve_evaluator.sv
tb/tb_top.sv
